FILE: rtl/fhash_pkg.sv
`default_nettype none

package fhash_pkg;

  // Pool and table geometry. BUCKETS must stay a power of two: the bucket
  // index is the low bits of the hash sum.
  localparam int BUCKETS  = 256;
  localparam int ENTRIES  = 1024;
  localparam int BKT_W    = $clog2(BUCKETS);
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  // Fixed field widths of the channels.
  localparam int NAME_W   = 32;
  localparam int ARITY_W  = 8;
  localparam int HANDLE_W = 10;

  // Hash shift applied to the name word.
  localparam int NAME_SHIFT = 2;

  typedef logic [BKT_W-1:0] bkt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One pool entry as stored in the entry memory.
  typedef struct packed {
    logic               lnk_vld;
    idx_t               lnk;
    logic [ARITY_W-1:0] arity;
    logic [NAME_W-1:0]  name;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_CMP,
    ST_MISS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;    // capture the input word, read the chain head
    logic head_load;  // start the walk at the chain head
    logic walk_rd;    // read the current entry
    logic step;       // follow the link of the current entry
    logic set_hit;    // result: existing entry
    logic do_insert;  // store a new entry at the chain head
    logic set_full;   // result: pool exhausted
    logic out_load;   // move the result into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic walk_ok;    // current link is valid and within the walk bound
    logic match;      // current entry equals the captured pair
    logic pool_full;  // no free pool entry
    logic out_free;   // output register can take a result this cycle
  } ctl_sts_t;

  function automatic bkt_t bucket_of(input logic [NAME_W-1:0] name,
                                     input logic [ARITY_W-1:0] arity);
    logic [NAME_W-1:0] sum;
    sum = (name >> NAME_SHIFT) + NAME_W'(arity);
    return sum[BKT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/functor_intern_hash_table.sv
// Sequence: the input word is taken only while idle; the chain head is read, then the
//   chain is walked until a match (hit) or its end (miss, which inserts or reports full).
// The walk is set by the single entry memory port, one read and one compare per entry;
//   a new word is taken once the result has moved into the output register.
// Reset (synchronous, rst_n low): clears all chain-head valid bits, the pool count, the
//   controller state and the output valid; the pool memories are not cleared.
`default_nettype none

module functor_intern_hash_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_name_word,
  input  wire logic [7:0]  in_arity,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       out_handle,
  output logic             out_found,
  output logic             out_full_res
);
  import fhash_pkg::*;

  // Command and status between the sequencer and the table datapath.
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // The sequencer takes one word at a time: capture, read the chain head,
  // then walk the chain one entry per read/compare pair. A miss links a new
  // pool entry at the chain head, or reports full when the pool is used up.
  fhash_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds the head table, the pool memory, the walk pointer
  // and the output register. The output register lets the next input word
  // be taken while a finished result still waits downstream.
  fhash_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_name_word (in_name_word),
    .in_arity     (in_arity),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_handle   (out_handle),
    .out_found    (out_found),
    .out_full_res (out_full_res)
  );

endmodule

`default_nettype wire

FILE: rtl/fhash_dp.sv
`default_nettype none

module fhash_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fhash_pkg::ctl_cmd_t           cmd,
  output fhash_pkg::ctl_sts_t                sts,
  input  wire logic [fhash_pkg::NAME_W-1:0]  in_name_word,
  input  wire logic [fhash_pkg::ARITY_W-1:0] in_arity,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [fhash_pkg::HANDLE_W-1:0]     out_handle,
  output logic                               out_found,
  output logic                               out_full_res
);
  import fhash_pkg::*;

  // Chain heads: valid bits in flops, indexes in a memory.
  logic [BUCKETS-1:0] head_vld_r, head_vld_nxt;
  idx_t               head_mem [BUCKETS];
  idx_t               head_rd_r;

  entry_t             entry_mem [ENTRIES];
  entry_t             ent_rd_r;

  logic [NAME_W-1:0]  name_r;
  logic [ARITY_W-1:0] arity_r;
  bkt_t               bucket_r;

  logic               hvld_r;
  idx_t               hidx_r;

  logic               cur_vld_r;
  idx_t               cur_r;
  cnt_t               steps_r;
  cnt_t               used_r;

  logic [HANDLE_W-1:0] res_handle_r;
  logic                res_found_r;
  logic                res_full_r;
  logic                out_valid_r;

  entry_t              new_ent;

  always_comb begin
    new_ent.lnk_vld = hvld_r;
    new_ent.lnk     = hidx_r;
    new_ent.arity   = arity_r;
    new_ent.name    = name_r;
  end

  always_comb begin
    head_vld_nxt = head_vld_r;
    if (cmd.do_insert) begin
      head_vld_nxt[bucket_r] = 1'b1;
    end
  end

  always_comb begin
    sts.walk_ok   = cur_vld_r && (CNT_W'(cur_r) < CNT_W'(ENTRIES)) && (steps_r < used_r);
    sts.match     = (ent_rd_r.name == name_r) && (ent_rd_r.arity == arity_r);
    sts.pool_full = (used_r >= CNT_W'(ENTRIES));
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Memories: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      head_rd_r <= head_mem[bucket_of(in_name_word, in_arity)];
    end
    if (cmd.do_insert) begin
      head_mem[bucket_r] <= used_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_rd) begin
      ent_rd_r <= entry_mem[cur_r];
    end
    if (cmd.do_insert) begin
      entry_mem[used_r[IDX_W-1:0]] <= new_ent;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      name_r   <= in_name_word;
      arity_r  <= in_arity;
      bucket_r <= bucket_of(in_name_word, in_arity);
    end
    if (cmd.head_load) begin
      hvld_r    <= head_vld_r[bucket_r];
      hidx_r    <= head_rd_r;
      cur_vld_r <= head_vld_r[bucket_r];
      cur_r     <= head_rd_r;
      steps_r   <= '0;
    end else if (cmd.step) begin
      cur_vld_r <= ent_rd_r.lnk_vld;
      cur_r     <= ent_rd_r.lnk;
      steps_r   <= steps_r + 1'b1;
    end
    if (cmd.set_hit) begin
      res_handle_r <= HANDLE_W'(cur_r);
      res_found_r  <= 1'b1;
      res_full_r   <= 1'b0;
    end else if (cmd.set_full) begin
      res_handle_r <= '0;
      res_found_r  <= 1'b0;
      res_full_r   <= 1'b1;
    end else if (cmd.do_insert) begin
      res_handle_r <= HANDLE_W'(used_r);
      res_found_r  <= 1'b0;
      res_full_r   <= 1'b0;
    end
    if (cmd.out_load) begin
      out_handle   <= res_handle_r;
      out_found    <= res_found_r;
      out_full_res <= res_full_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r  <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      if (cmd.do_insert) begin
        used_r <= used_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/fhash_ctl.sv
`default_nettype none

module fhash_ctl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output fhash_pkg::ctl_cmd_t      cmd,
  input  wire fhash_pkg::ctl_sts_t sts
);
  import fhash_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_HEAD;
        end
      end
      ST_HEAD: begin
        cmd.head_load = 1'b1;
        state_nxt     = ST_WALK;
      end
      ST_WALK: begin
        if (sts.walk_ok) begin
          cmd.walk_rd = 1'b1;
          state_nxt   = ST_CMP;
        end else begin
          state_nxt = ST_MISS;
        end
      end
      ST_CMP: begin
        if (sts.match) begin
          cmd.set_hit = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_MISS: begin
        if (sts.pool_full) begin
          cmd.set_full = 1'b1;
        end else begin
          cmd.do_insert = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
